/* hw/rtl/c3s_pkg.sv */
package c3s_pkg;

    // Field widths
    localparam int PIX_W  = 16;
    localparam int SUM_W  = 35;
    localparam int ROW_W  = 16;
    localparam int OCOL_W = 10;
    localparam int IMGW_W = 11;
    localparam int COEF_W = 48;
    localparam int PROD_W = 2 * PIX_W;
    localparam int PSUM_W = PROD_W + 2;

    // APB geometry: 64-bit registers at 8-byte spacing
    localparam int APB_AW = 6;
    localparam int APB_DW = 64;
    localparam int IDX_W  = 3;

    typedef logic [IDX_W-1:0] t_reg_idx;

    localparam t_reg_idx REG_IMAGE_WIDTH  = 3'd0;
    localparam t_reg_idx REG_IMAGE_HEIGHT = 3'd1;
    localparam t_reg_idx REG_COEF_TOP     = 3'd2;
    localparam t_reg_idx REG_COEF_MID     = 3'd3;
    localparam t_reg_idx REG_COEF_BOT     = 3'd4;

    localparam logic [IMGW_W-1:0] IMAGE_WIDTH_RST  = 11'd1024;
    localparam logic [ROW_W-1:0]  IMAGE_HEIGHT_RST = 16'd1024;

    // Per-beat side information that travels with the pixel
    typedef struct packed {
        logic              emit;
        logic              last;
        logic [ROW_W-1:0]  row;
        logic [OCOL_W-1:0] col;
    } t_meta;

endpackage

/* hw/rtl/conv3x3_stream.sv */
// A pixel accepted at a rising edge is registered with its line store read in stage 1,
// then passes through the window, product, row-sum and output registers; the whole
// pipe holds while the output beat is stalled.
// Throughput: one pixel per cycle while the output beat is not stalled; each line store
// entry is read in the accept cycle and written back at the next pipeline advance through a single memory.
// Reset (i_rst_n low, synchronous): counters, window, pipeline valids and config
// registers return to defaults; the line store is not cleared.
module conv3x3_stream #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // pixel input
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [c3s_pkg::PIX_W-1:0]    i_pixel_value,
    // result output
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [c3s_pkg::SUM_W-1:0]    o_conv_sum,
    output logic [c3s_pkg::ROW_W-1:0]           o_out_row,
    output logic [c3s_pkg::OCOL_W-1:0]          o_out_col,
    output logic                                o_last_result,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [c3s_pkg::APB_AW-1:0]          paddr,
    input  logic [c3s_pkg::APB_DW-1:0]          pwdata,
    output logic [c3s_pkg::APB_DW-1:0]          prdata,
    output logic                                pready
);
    import c3s_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int XW  = (WW > IMGW_W) ? WW : IMGW_W;
    localparam int LSW = 2 * PIX_W;

    // Config registers
    logic [IMGW_W-1:0] r_img_w;
    logic [ROW_W-1:0]  r_img_h;
    logic [COEF_W-1:0] r_coef [3];

    t_reg_idx w_idx;
    logic     w_cfg_wr;

    assign pready   = 1'b1;
    assign w_idx    = paddr[APB_AW-1:APB_AW-IDX_W];
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w   <= IMAGE_WIDTH_RST;
            r_img_h   <= IMAGE_HEIGHT_RST;
            r_coef[0] <= '0;
            r_coef[1] <= '0;
            r_coef[2] <= '0;
        end else if (w_cfg_wr) begin
            case (w_idx)
                REG_IMAGE_WIDTH:  r_img_w   <= pwdata[IMGW_W-1:0];
                REG_IMAGE_HEIGHT: r_img_h   <= pwdata[ROW_W-1:0];
                REG_COEF_TOP:     r_coef[0] <= pwdata[COEF_W-1:0];
                REG_COEF_MID:     r_coef[1] <= pwdata[COEF_W-1:0];
                REG_COEF_BOT:     r_coef[2] <= pwdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (w_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DW'(r_img_w);
            REG_IMAGE_HEIGHT: prdata = APB_DW'(r_img_h);
            REG_COEF_TOP:     prdata = APB_DW'(r_coef[0]);
            REG_COEF_MID:     prdata = APB_DW'(r_coef[1]);
            REG_COEF_BOT:     prdata = APB_DW'(r_coef[2]);
            default:          prdata = '0;
        endcase
    end

    // Pipeline advance: whole pipe moves unless the output beat is stalled
    logic w_en;
    logic w_accept;

    assign w_en     = !o_valid || i_ready;
    assign o_ready  = w_en;
    assign w_accept = i_valid && w_en;

    // Effective geometry
    logic [XW-1:0]    w_wext;
    logic [XW-1:0]    w_eff_w;
    logic [ROW_W-1:0] w_eff_h;
    logic [XW-1:0]    w_col_ext;
    logic [XW-1:0]    w_col_m2;
    logic             w_row_end;
    logic             w_img_end;
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    t_meta            w_meta;

    assign w_wext    = XW'(r_img_w);
    assign w_col_ext = XW'(r_col);
    assign w_col_m2  = w_col_ext - XW'(2);

    always_comb begin
        if (w_wext < XW'(3)) begin
            w_eff_w = XW'(3);
        end else if (w_wext > XW'(MAX_WIDTH)) begin
            w_eff_w = XW'(MAX_WIDTH);
        end else begin
            w_eff_w = w_wext;
        end
        w_eff_h = (r_img_h < ROW_W'(3)) ? ROW_W'(3) : r_img_h;
    end

    assign w_row_end = (w_col_ext + XW'(1)) >= w_eff_w;
    assign w_img_end = w_row_end &&
                       (({1'b0, r_row} + (ROW_W+1)'(1)) >= {1'b0, w_eff_h});

    always_comb begin
        w_meta.emit = (r_row >= ROW_W'(2)) && (r_col >= CW'(2));
        w_meta.last = w_img_end;
        w_meta.row  = r_row - ROW_W'(2);
        w_meta.col  = w_col_m2[OCOL_W-1:0];
    end

    // Raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            if (w_row_end) begin
                r_col <= '0;
                r_row <= w_img_end ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // Stage 1 registers: pixel, column, side info
    logic                    r_v1;
    logic signed [PIX_W-1:0] r_s1_px;
    logic [CW-1:0]           r_s1_col;
    t_meta                   r_s1_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_px   <= i_pixel_value;
            r_s1_col  <= r_col;
            r_s1_meta <= w_meta;
        end
    end

    // Line store: {older row, newer row} per column; read on accept, written back
    // at the next pipeline advance (consecutive beats never share a column)
    logic [LSW-1:0] r_mem [MAX_WIDTH];
    logic [LSW-1:0] r_rd;
    logic [PIX_W-1:0] w_top;
    logic [PIX_W-1:0] w_mid;

    assign w_top = r_rd[LSW-1:PIX_W];
    assign w_mid = r_rd[PIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_en && r_v1) begin
            r_mem[r_s1_col] <= {w_mid, r_s1_px};
        end
        if (w_accept) begin
            r_rd <= r_mem[r_col];
        end
    end

    // Window shift
    logic signed [PIX_W-1:0] r_win [9];
    logic                    r_vw;
    t_meta                   r_w_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vw <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (w_en) begin
            r_vw <= r_v1 && r_s1_meta.emit;
            if (r_v1) begin
                for (int m = 0; m < 3; m++) begin
                    r_win[m*3+0] <= r_win[m*3+1];
                    r_win[m*3+1] <= r_win[m*3+2];
                end
                r_win[2] <= w_top;
                r_win[5] <= w_mid;
                r_win[8] <= r_s1_px;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_w_meta <= r_s1_meta;
        end
    end

    // Nine products
    logic signed [PROD_W-1:0] r_prod [9];
    logic                     r_vp;
    t_meta                    r_p_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
        end else if (w_en) begin
            r_vp <= r_vw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_meta <= r_w_meta;
            for (int m = 0; m < 3; m++) begin
                for (int n = 0; n < 3; n++) begin
                    r_prod[m*3+n] <= r_win[m*3+n] * signed'(r_coef[m][16*n +: PIX_W]);
                end
            end
        end
    end

    // Row sums
    logic signed [PSUM_W-1:0] r_psum [3];
    logic                     r_vs;
    t_meta                    r_s_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs <= 1'b0;
        end else if (w_en) begin
            r_vs <= r_vp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s_meta <= r_p_meta;
            for (int m = 0; m < 3; m++) begin
                r_psum[m] <= PSUM_W'(r_prod[m*3+0]) + PSUM_W'(r_prod[m*3+1])
                           + PSUM_W'(r_prod[m*3+2]);
            end
        end
    end

    // Output register
    logic                    r_out_valid;
    logic signed [SUM_W-1:0] r_sum;
    t_meta                   r_o_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_vs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_meta <= r_s_meta;
            r_sum    <= SUM_W'(r_psum[0]) + SUM_W'(r_psum[1]) + SUM_W'(r_psum[2]);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_conv_sum    = r_sum;
    assign o_out_row     = r_o_meta.row;
    assign o_out_col     = r_o_meta.col;
    assign o_last_result = r_o_meta.last;

    // Checks
    a_ls_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_v1) |-> (r_col != r_s1_col))
        else $error("line store read and write-back hit the same column");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row != {ROW_W{1'b1}})
        else $error("row counter ran past the largest image height");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_vs))
        else $error("result appeared without a row-sum beat behind it");

endmodule

/* test/tb_top.sv */
module tb_top;
    import c3s_pkg::*;

    localparam int MAX_W        = 1024;
    localparam int DRAIN_CYCLES = 12;
    localparam int SMALL_ITEMS  = 860;
    localparam int MAX_REPORTS  = 100;
    localparam int LEAD_COLS    = 40;
    localparam int SMALL_W_MAX  = 24;

    // Directed table: register writes, plain pixels, and pixels whose result is known by hand
    typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_PIX_CHK} t_row_kind;

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [ROW_W-1:0]  row;
        logic [OCOL_W-1:0] col;
        logic              last;
    } t_conv_out;

    typedef struct packed {
        t_row_kind   kind;
        t_reg_idx    reg_idx;   // don't care on pixel rows
        logic [63:0] wdata;     // register value, or pixel in the low 16 bits
        t_conv_out   res;       // hand-computed result on checked rows
    } t_dir_row;

    localparam logic [63:0] COEF_ALL_MIN = 64'h0000_8000_8000_8000;
    localparam logic [63:0] COEF_ALL_MAX = 64'h0000_7FFF_7FFF_7FFF;
    localparam logic [63:0] PIX_MIN      = 64'h8000;
    localparam logic [63:0] PIX_MAX      = 64'h7FFF;
    localparam t_conv_out   NO_RES       = '0;

    // Two 3x3 images (width and height written below the minimum): all-negative pixels
    // times all-negative coefficients gives the largest sum, then the most positive pair.
    localparam int DIR_N = 26;
    localparam t_dir_row DIR_TBL [DIR_N] = '{
        '{ROW_CFG, REG_IMAGE_WIDTH,  64'd0,        NO_RES},
        '{ROW_CFG, REG_IMAGE_HEIGHT, 64'd1,        NO_RES},
        '{ROW_CFG, REG_COEF_TOP,     COEF_ALL_MIN, NO_RES},
        '{ROW_CFG, REG_COEF_MID,     COEF_ALL_MIN, NO_RES},
        '{ROW_CFG, REG_COEF_BOT,     COEF_ALL_MIN, NO_RES},
        '{ROW_PIX, REG_IMAGE_WIDTH,  PIX_MIN,      NO_RES},
        '{ROW_PIX, REG_IMAGE_WIDTH,  PIX_MIN,      NO_RES},
        '{ROW_PIX, REG_IMAGE_WIDTH,  PIX_MIN,      NO_RES},
        '{ROW_PIX, REG_IMAGE_WIDTH,  PIX_MIN,      NO_RES},
        '{ROW_PIX, REG_IMAGE_WIDTH,  PIX_MIN,      NO_RES},
        '{ROW_PIX, REG_IMAGE_WIDTH,  PIX_MIN,      NO_RES},
        '{ROW_PIX, REG_IMAGE_WIDTH,  PIX_MIN,      NO_RES},
        '{ROW_PIX, REG_IMAGE_WIDTH,  PIX_MIN,      NO_RES},
        '{ROW_PIX_CHK, REG_IMAGE_WIDTH, PIX_MIN,
          '{35'd9663676416, 16'd0, 10'd0, 1'b1}},
        '{ROW_CFG, REG_COEF_TOP,     COEF_ALL_MAX, NO_RES},
        '{ROW_CFG, REG_COEF_MID,     COEF_ALL_MAX, NO_RES},
        '{ROW_CFG, REG_COEF_BOT,     COEF_ALL_MAX, NO_RES},
        '{ROW_PIX, REG_IMAGE_WIDTH,  PIX_MAX,      NO_RES},
        '{ROW_PIX, REG_IMAGE_WIDTH,  PIX_MAX,      NO_RES},
        '{ROW_PIX, REG_IMAGE_WIDTH,  PIX_MAX,      NO_RES},
        '{ROW_PIX, REG_IMAGE_WIDTH,  PIX_MAX,      NO_RES},
        '{ROW_PIX, REG_IMAGE_WIDTH,  PIX_MAX,      NO_RES},
        '{ROW_PIX, REG_IMAGE_WIDTH,  PIX_MAX,      NO_RES},
        '{ROW_PIX, REG_IMAGE_WIDTH,  PIX_MAX,      NO_RES},
        '{ROW_PIX, REG_IMAGE_WIDTH,  PIX_MAX,      NO_RES},
        '{ROW_PIX_CHK, REG_IMAGE_WIDTH, PIX_MAX,
          '{35'd9663086601, 16'd0, 10'd0, 1'b1}}
    };

    // DUT connections
    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic signed [PIX_W-1:0]  i_pixel_value = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic signed [SUM_W-1:0]  o_conv_sum;
    logic [ROW_W-1:0]         o_out_row;
    logic [OCOL_W-1:0]        o_out_col;
    logic                     o_last_result;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_AW-1:0]        paddr = '0;
    logic [APB_DW-1:0]        pwdata = '0;
    logic [APB_DW-1:0]        prdata;
    logic                     pready;

    conv3x3_stream #(.MAX_WIDTH(MAX_W)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel_value (i_pixel_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_conv_sum    (o_conv_sum),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_last_result (o_last_result),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the block: geometry, kernel, line stores, window and counters
    logic [IMGW_W-1:0] cfg_width  = IMAGE_WIDTH_RST;
    logic [ROW_W-1:0]  cfg_height = IMAGE_HEIGHT_RST;
    logic [COEF_W-1:0] cfg_coef [3] = '{default: '0};
    logic [PIX_W-1:0]  line_older [MAX_W];
    logic [PIX_W-1:0]  line_newer [MAX_W];
    logic [PIX_W-1:0]  win [9] = '{default: '0};
    int unsigned       col_cnt = 0;
    int unsigned       row_cnt = 0;

    t_conv_out conv_due [$];     // window sums still to come out, oldest first

    int snd_idle_pct = 30;
    int rcv_idle_pct = 61;
    int err_count    = 0;
    int n_px         = 0;
    int n_checked    = 0;
    int n_writes     = 0;
    int n_settings   = 0;

    initial begin
        for (int k = 0; k < MAX_W; k++) begin
            line_older[k] = '0;
            line_newer[k] = '0;
        end
    end

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    endtask

    // Shift the window by one pixel; a full window gives a sum at the top-left corner
    task automatic slide_window(input logic [PIX_W-1:0] px, output bit emitted,
                                output t_conv_out res);
        int unsigned     w, h, c, r;
        bit              row_end, img_end;
        longint          acc;
        logic [PIX_W-1:0] top, mid;
        w = (cfg_width < 3) ? 3 : ((cfg_width > MAX_W) ? MAX_W : cfg_width);
        h = (cfg_height < 3) ? 3 : cfg_height;
        c = col_cnt % MAX_W;
        r = row_cnt;
        top = line_older[c];
        mid = line_newer[c];
        row_end = (col_cnt + 1 >= w);
        img_end = row_end && (r + 1 >= h);
        for (int m = 0; m < 3; m++) begin
            win[3*m]   = win[3*m+1];
            win[3*m+1] = win[3*m+2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = px;
        line_older[c] = mid;
        line_newer[c] = px;

        res = '0;
        emitted = (r >= 2) && (col_cnt >= 2);
        if (emitted) begin
            acc = 0;
            for (int m = 0; m < 3; m++)
                for (int n = 0; n < 3; n++)
                    acc += longint'($signed(win[3*m+n])) *
                           longint'($signed(cfg_coef[m][16*n +: 16]));
            res.sum  = acc[SUM_W-1:0];
            res.row  = ROW_W'(r - 2);
            res.col  = OCOL_W'(col_cnt - 2);
            res.last = img_end;
        end

        // wrap column at row end, row at image end
        if (row_end) begin
            col_cnt = 0;
            row_cnt = img_end ? 0 : ((r + 1) & 16'hFFFF);
        end else begin
            col_cnt = col_cnt + 1;
        end
    endtask

    // APB write, then read back the value the register keeps
    task automatic write_reg(input t_reg_idx idx, input logic [63:0] val);
        logic [63:0] kept;
        case (idx)
            REG_IMAGE_WIDTH: begin
                cfg_width = val[IMGW_W-1:0];
                kept = 64'(val[IMGW_W-1:0]);
            end
            REG_IMAGE_HEIGHT: begin
                cfg_height = val[ROW_W-1:0];
                kept = 64'(val[ROW_W-1:0]);
            end
            REG_COEF_TOP: begin
                cfg_coef[0] = val[COEF_W-1:0];
                kept = 64'(val[COEF_W-1:0]);
            end
            REG_COEF_MID: begin
                cfg_coef[1] = val[COEF_W-1:0];
                kept = 64'(val[COEF_W-1:0]);
            end
            REG_COEF_BOT: begin
                cfg_coef[2] = val[COEF_W-1:0];
                kept = 64'(val[COEF_W-1:0]);
            end
            default: kept = '0;
        endcase

        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        // read phase on the same address
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== kept)
            flag_mismatch("register readback", prdata, kept);
        psel    <= 1'b0;
        penable <= 1'b0;
        n_writes++;
    endtask

    // Present one pixel beat with a random lead-in gap; predict at acceptance
    task automatic send_pixel(input logic [PIX_W-1:0] px, output bit emitted,
                              output t_conv_out res);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_pixel_value <= px;
        do @(posedge i_clk); while (!o_ready);
        slide_window(px, emitted, res);
        n_px++;
    endtask

    task automatic feed(input logic [PIX_W-1:0] px);
        bit        emitted;
        t_conv_out res;
        send_pixel(px, emitted, res);
        if (emitted)
            conv_due.push_back(res);
    endtask

    // Hold the pixel stream until the pipeline has emptied
    task automatic settle();
        i_valid <= 1'b0;
        while (conv_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Extremes and sign patterns show up often, the rest is uniform
    function automatic logic [15:0] rand_word16();
        case ($urandom_range(19))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] rand_coef();
        return {16'($urandom), rand_word16(), rand_word16(), rand_word16()};
    endfunction

    // Result side: random stalls, compare each beat with the oldest prediction
    always @(posedge i_clk) begin : result_side
        t_conv_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (conv_due.size() == 0) begin
                flag_mismatch("result with nothing pending", 64'(o_conv_sum), '0);
            end else begin
                want = conv_due.pop_front();
                if (o_conv_sum !== want.sum)
                    flag_mismatch("conv_sum", 64'(o_conv_sum), 64'(want.sum));
                if (o_out_row !== want.row)
                    flag_mismatch("out_row", 64'(o_out_row), 64'(want.row));
                if (o_out_col !== want.col)
                    flag_mismatch("out_col", 64'(o_out_col), 64'(want.col));
                if (o_last_result !== want.last)
                    flag_mismatch("last_result", 64'(o_last_result), 64'(want.last));
                n_checked++;
            end
        end
        i_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    initial begin : stimulus
        bit          emitted;
        t_conv_out   res;
        logic [4:0]  pick;
        logic [10:0] w_val;
        logic [15:0] h_val;
        int          n_small;

        n_small = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int i = 0; i < DIR_N; i++) begin
            if (DIR_TBL[i].kind == ROW_CFG) begin
                settle();
                write_reg(DIR_TBL[i].reg_idx, DIR_TBL[i].wdata);
            end else begin
                send_pixel(DIR_TBL[i].wdata[PIX_W-1:0], emitted, res);
                if (DIR_TBL[i].kind == ROW_PIX_CHK)
                    conv_due.push_back(DIR_TBL[i].res);
                else if (emitted)
                    conv_due.push_back(res);
            end
        end
        n_settings += 2;

        // width written above the maximum is held at the line store depth: part of row 0
        settle();
        write_reg(REG_IMAGE_WIDTH, {32'($urandom), 21'($urandom), 11'd2047});
        write_reg(REG_IMAGE_HEIGHT, {32'($urandom), 16'($urandom), 16'd3});
        write_reg(REG_COEF_TOP, rand_coef());
        write_reg(REG_COEF_MID, rand_coef());
        write_reg(REG_COEF_BOT, rand_coef());
        n_settings++;
        repeat (LEAD_COLS) feed(rand_word16());

        // shrink the width below the current column: the row ends at once, then one
        // full row at the widest small width fills both line stores for what follows
        settle();
        write_reg(REG_IMAGE_WIDTH, 64'(SMALL_W_MAX));
        n_settings++;
        repeat (SMALL_W_MAX + 1) feed(rand_word16());

        // short random phases; geometry and kernel change wherever the stream stands
        while (n_small < SMALL_ITEMS) begin
            settle();
            if (n_small < SMALL_ITEMS / 3) begin
                snd_idle_pct = 30;
                rcv_idle_pct = 61;
            end else if (n_small < 2 * SMALL_ITEMS / 3) begin
                snd_idle_pct = 61;
                rcv_idle_pct = 30;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end

            w_val = ($urandom_range(9) == 0) ? 11'($urandom_range(2))
                                             : 11'($urandom_range(3, SMALL_W_MAX));
            case ($urandom_range(9))
                0:       h_val = 16'($urandom_range(2));
                1:       h_val = 16'hFFFF;
                2:       h_val = 16'($urandom);
                default: h_val = 16'($urandom_range(3, 7));
            endcase
            pick = 5'($urandom_range(1, 31));
            if (pick[0]) write_reg(REG_IMAGE_WIDTH, {32'($urandom), 21'($urandom), w_val});
            if (pick[1]) write_reg(REG_IMAGE_HEIGHT, {32'($urandom), 16'($urandom), h_val});
            if (pick[2]) write_reg(REG_COEF_TOP, rand_coef());
            if (pick[3]) write_reg(REG_COEF_MID, rand_coef());
            if (pick[4]) write_reg(REG_COEF_BOT, rand_coef());
            n_settings++;

            repeat ($urandom_range(15, 70)) begin
                feed(rand_word16());
                n_small++;
            end
        end

        // drain and wrap up
        settle();
        repeat (20) @(posedge i_clk);
        if (conv_due.size() != 0)
            flag_mismatch("results never delivered", 64'(conv_due.size()), '0);

        $display("Streamed %0d pixels over %0d register settings, widths 3 to 1024,",
                 n_px, n_settings);
        $display("heights 3 to 65535; %0d window sums checked, %0d register writes read back",
                 n_checked, n_writes);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/c3s_pkg.sv
hw/rtl/conv3x3_stream.sv
test/tb_top.sv
